>>> hdl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define BRMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define BRMC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/brmc_pkg.sv
package brmc_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_ELEMENTS = 8;
    localparam int DEF_BLOCK_BITS   = 63;

    // Fixed field widths of the stream items.
    localparam int CLASS_INPUTS = 8;
    localparam int CLASS_W      = 63;
    localparam int COUNT_W      = 6;
    localparam int TOTAL_W      = 40;
    localparam int IN_TDATA_W   = CLASS_INPUTS * CLASS_W;
    localparam int OUT_FIELDS_W = CLASS_W + COUNT_W + TOTAL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int ELEM_COUNT_W = 4;
    localparam int STAR_W       = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_INDEX_W  = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ELEMENT_COUNT = 2'd0,
        REG_STAR_MASK     = 2'd1
    } brmc_reg_t;

    typedef struct packed {
        logic [ELEM_COUNT_W-1:0] element_count;
        logic [STAR_W-1:0]       star_mask;
    } brmc_cfg_t;

    typedef logic [CLASS_INPUTS-1:0][CLASS_W-1:0] brmc_class_t;

    // One text block as it enters the marker chain.
    typedef struct packed {
        logic        start;
        brmc_class_t classes;
    } brmc_item_t;

    // Final marker of one block on its way to the counters.
    typedef struct packed {
        logic               start;
        logic [CLASS_W-1:0] marker;
    } brmc_mark_t;

endpackage

>>> hdl/brmc_element.sv
module brmc_element
    import brmc_pkg::*;
#(
    parameter int BLOCK_BITS = DEF_BLOCK_BITS
)(
    input  logic [BLOCK_BITS-1:0] marker_in,
    input  logic [BLOCK_BITS-1:0] cls,
    input  logic                  carry_in,
    input  logic                  star,
    output logic [BLOCK_BITS-1:0] marker_out,
    output logic                  carry_out
);

    localparam int SUM_W = BLOCK_BITS + 1;

    logic [BLOCK_BITS-1:0] masked;
    logic [SUM_W-1:0]      sum;

    // MatchStar spreads the marker through runs of the class with one add.
    assign masked = marker_in & cls;
    assign sum    = {1'b0, masked} + {1'b0, cls} + SUM_W'(carry_in);

    // Advance moves matched positions one character on; the top bit crosses
    // into the next block.
    always_comb
    begin
        if (star)
        begin
            marker_out = (sum[BLOCK_BITS-1:0] ^ cls) | marker_in;
            carry_out  = sum[BLOCK_BITS];
        end
        else
        begin
            marker_out = {masked[BLOCK_BITS-2:0], carry_in};
            carry_out  = masked[BLOCK_BITS-1];
        end
    end

endmodule

>>> hdl/brmc_chain.sv
module brmc_chain
    import brmc_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int BLOCK_BITS   = DEF_BLOCK_BITS
)(
    input  logic       clk,
    input  logic       rst_n,
    input  brmc_cfg_t  cfg,
    input  logic       in_valid,
    input  brmc_item_t in_item,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output brmc_mark_t out_mark
);

    logic [MAX_ELEMENTS:0][BLOCK_BITS-1:0]   marker_w;
    logic [MAX_ELEMENTS-1:0][BLOCK_BITS-1:0] elem_marker;
    logic [MAX_ELEMENTS-1:0]                 carry_reg;
    logic [MAX_ELEMENTS-1:0]                 carry_next;
    logic [MAX_ELEMENTS-1:0]                 carry_in;
    logic [MAX_ELEMENTS-1:0]                 carry_out;
    logic [MAX_ELEMENTS-1:0]                 active;
    logic                                    valid_reg;
    brmc_mark_t                              mark_reg;
    brmc_mark_t                              mark_next;
    logic                                    take;

    // The stage takes an item when it is empty or its item leaves this cycle.
    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // A start of text clears the carries before the block is processed.
    assign carry_in    = in_item.start ? '0 : carry_reg;
    assign marker_w[0] = in_item.classes[0][BLOCK_BITS-1:0];

    // One transform per pattern element; unused elements pass the marker on
    // and keep their carry.
    for (genvar g = 0; g < MAX_ELEMENTS; g++)
    begin : g_elem
        assign active[g] = (g == 0) || (cfg.element_count > ELEM_COUNT_W'(g));

        brmc_element #(
            .BLOCK_BITS (BLOCK_BITS)
        ) u_element (
            .marker_in  (marker_w[g]),
            .cls        (in_item.classes[g][BLOCK_BITS-1:0]),
            .carry_in   (carry_in[g]),
            .star       (cfg.star_mask[g]),
            .marker_out (elem_marker[g]),
            .carry_out  (carry_out[g])
        );

        assign marker_w[g+1] = active[g] ? elem_marker[g] : marker_w[g];
        assign carry_next[g] = active[g] ? carry_out[g] : carry_in[g];
    end

    assign mark_next.start  = in_item.start;
    assign mark_next.marker = CLASS_W'(marker_w[MAX_ELEMENTS]);

    // Carries and stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (take)
            begin
                carry_reg <= carry_next;
            end
        end
    end

    // Marker payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mark_reg <= mark_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_mark  = mark_reg;

endmodule

>>> hdl/brmc_tally.sv
module brmc_tally
    import brmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  brmc_mark_t         in_mark,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CLASS_W-1:0] out_marker,
    output logic [COUNT_W-1:0] out_count,
    output logic [TOTAL_W-1:0] out_total
);

    localparam int SUM_W = TOTAL_W + 1;

    logic               cnt_valid_reg;
    logic               cnt_start_reg;
    logic [CLASS_W-1:0] cnt_marker_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic               out_valid_reg;
    logic [CLASS_W-1:0] out_marker_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [TOTAL_W-1:0] total_base;
    logic [SUM_W-1:0]   total_sum;
    logic               out_load;
    logic               cnt_load;
    logic               cnt_take;
    logic               out_take;

    function automatic logic [COUNT_W-1:0] count_ones(input logic [CLASS_W-1:0] v);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int k = 0; k < CLASS_W; k++)
        begin
            n = n + COUNT_W'(v[k]);
        end
        return n;
    endfunction

    // Each stage loads when it is empty or its item moves on.
    assign out_load = !out_valid_reg || out_ready;
    assign cnt_load = !cnt_valid_reg || out_load;
    assign in_ready = cnt_load;
    assign cnt_take = in_valid && cnt_load;
    assign out_take = cnt_valid_reg && out_load;

    assign cnt_next = count_ones(in_mark.marker);

    // Running total restarts with the start of text and sticks at its maximum.
    assign total_base = cnt_start_reg ? '0 : total_reg;
    assign total_sum  = {1'b0, total_base} + SUM_W'(cnt_reg);
    assign total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

    // Stage valids and the running total.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (cnt_load)
            begin
                cnt_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= cnt_valid_reg;
            end
            if (out_take)
            begin
                total_reg <= total_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cnt_take)
        begin
            cnt_start_reg  <= in_mark.start;
            cnt_marker_reg <= in_mark.marker;
            cnt_reg        <= cnt_next;
        end
        if (out_take)
        begin
            out_marker_reg <= cnt_marker_reg;
            out_count_reg  <= cnt_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_marker = out_marker_reg;
    assign out_count  = out_count_reg;
    assign out_total  = total_reg;

endmodule

>>> hdl/bitstream_regex_marker_chain.sv
// Bitstream regular-expression marker chain. Each item is one text block given
// as one character-class bitstream per pattern element; the block runs the
// Advance/MatchStar marker chain over the elements in use, keeps each element's
// carry-out for the next block, and returns the final marker, its match count
// and a saturating running total. One item is accepted every clock cycle while
// the result stream does not stall, and each accepted item passes four
// registers: input register, marker chain, population count, running total.
// The clock rate is set by the chain of up to eight dependent block-wide adds
// in the marker chain stage. Configuration may be written only while no item
// is in flight.
`include "assert_macros.svh"

module bitstream_regex_marker_chain
    import brmc_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int BLOCK_BITS   = DEF_BLOCK_BITS
)(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // class_bits_0 .. class_bits_7
    input  logic                   s_tuser,   // start_of_text
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // final_marker, block_matches,
                                              // total_matches, zero pad
);

    localparam int PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

    brmc_cfg_t          cfg_reg;
    logic               in_valid_reg;
    brmc_item_t         in_item_reg;
    brmc_item_t         in_item_next;
    logic               chain_ready;
    logic               chain_valid;
    brmc_mark_t         chain_mark;
    logic               tally_ready;
    logic [CLASS_W-1:0] final_marker;
    logic [COUNT_W-1:0] block_matches;
    logic [TOTAL_W-1:0] total_matches;

    // Configuration registers; writes to other indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.element_count <= ELEM_COUNT_W'(1);
            cfg_reg.star_mask     <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ELEMENT_COUNT)
            begin
                cfg_reg.element_count <= cfg_data[ELEM_COUNT_W-1:0];
            end
            else if (cfg_index == REG_STAR_MASK)
            begin
                cfg_reg.star_mask <= cfg_data[STAR_W-1:0];
            end
        end
    end

    // Input register stage.
    assign s_tready             = !in_valid_reg || chain_ready;
    assign in_item_next.start   = s_tuser;
    assign in_item_next.classes = s_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item_next;
        end
    end

    // Marker chain with per-element carries.
    brmc_chain #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .BLOCK_BITS   (BLOCK_BITS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid_reg),
        .in_item   (in_item_reg),
        .in_ready  (chain_ready),
        .out_valid (chain_valid),
        .out_ready (tally_ready),
        .out_mark  (chain_mark)
    );

    // Match count and running total.
    brmc_tally u_tally (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chain_valid),
        .in_mark    (chain_mark),
        .in_ready   (tally_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_marker (final_marker),
        .out_count  (block_matches),
        .out_total  (total_matches)
    );

    assign m_tdata = {PAD_W'(0), total_matches, block_matches, final_marker};

    // With nothing waiting at the output, no stage can hold back the input.
    `BRMC_ASSERT_ALWAYS(a_ready_when_drained, !m_tvalid |-> s_tready,
        "input stalled although the result stage is empty")

    // The reported count matches the reported marker.
    `BRMC_ASSERT(a_count_matches_marker,
        m_tvalid |-> ($countones(final_marker) == 32'(block_matches)),
        "block match count differs from the final marker")

    // No marker bit beyond the block length.
    `BRMC_ASSERT(a_marker_in_block,
        m_tvalid |-> ((final_marker >> BLOCK_BITS) == '0),
        "final marker has bits beyond the block length")

    // The running total always includes this block's matches.
    `BRMC_ASSERT(a_total_covers_block,
        m_tvalid |-> (total_matches >= TOTAL_W'(block_matches)),
        "running total smaller than the block count")

endmodule
